[design/affine_box_transform_defines.svh]
// Assertion macros used by the checker file of affine_box_transform.
`ifndef AFFINE_BOX_TRANSFORM_DEFINES_SVH
`define AFFINE_BOX_TRANSFORM_DEFINES_SVH

// Implication that must hold in the same cycle.
`define ABT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold a fixed number of cycles later.
`define ABT_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[design/abt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_pkg
// Constants and types shared by the affine box transform modules.
// ----------------------------------------------------------------------------
package abt_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int COEF_BITS_DEF  = 18;
	localparam int COEF_FRAC      = 14;
	localparam int COEF_ONE       = 1 << COEF_FRAC;
	localparam int NUM_REGS       = 8;
	localparam int ADDR_W         = $clog2(NUM_REGS) + 2;
	localparam int APB_DATA_W     = 32;
	localparam int NUM_LANES      = 4;
	localparam int PIPE_DEPTH     = 5;

	typedef enum logic [$clog2(NUM_REGS)-1:0] {
		REG_COEF_XX  = 3'd0,
		REG_COEF_XY  = 3'd1,
		REG_COEF_YX  = 3'd2,
		REG_COEF_YY  = 3'd3,
		REG_SHIFT_X  = 3'd4,
		REG_SHIFT_Y  = 3'd5,
		REG_CENTER_X = 3'd6,
		REG_CENTER_Y = 3'd7
	} reg_idx_t;

endpackage

[design/abt_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_regs
// APB register file holding the matrix, translation and center.
// ----------------------------------------------------------------------------
module abt_regs import abt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int COEF_BITS  = COEF_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready,
	output logic signed [COEF_BITS-1:0]  coef_xx,
	output logic signed [COEF_BITS-1:0]  coef_xy,
	output logic signed [COEF_BITS-1:0]  coef_yx,
	output logic signed [COEF_BITS-1:0]  coef_yy,
	output logic signed [COORD_BITS-1:0] shift_x,
	output logic signed [COORD_BITS-1:0] shift_y,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx  <= COEF_BITS'(COEF_ONE);
			coef_xy  <= '0;
			coef_yx  <= '0;
			coef_yy  <= COEF_BITS'(COEF_ONE);
			shift_x  <= '0;
			shift_y  <= '0;
			center_x <= '0;
			center_y <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_COEF_XX:  coef_xx  <= pwdata[COEF_BITS-1:0];
				REG_COEF_XY:  coef_xy  <= pwdata[COEF_BITS-1:0];
				REG_COEF_YX:  coef_yx  <= pwdata[COEF_BITS-1:0];
				REG_COEF_YY:  coef_yy  <= pwdata[COEF_BITS-1:0];
				REG_SHIFT_X:  shift_x  <= pwdata[COORD_BITS-1:0];
				REG_SHIFT_Y:  shift_y  <= pwdata[COORD_BITS-1:0];
				REG_CENTER_X: center_x <= pwdata[COORD_BITS-1:0];
				REG_CENTER_Y: center_y <= pwdata[COORD_BITS-1:0];
			endcase
		end
	end

	// Read back sign-extended to the bus width.
	always_comb begin
		unique case (idx)
			REG_COEF_XX:  prdata = APB_DATA_W'(coef_xx);
			REG_COEF_XY:  prdata = APB_DATA_W'(coef_xy);
			REG_COEF_YX:  prdata = APB_DATA_W'(coef_yx);
			REG_COEF_YY:  prdata = APB_DATA_W'(coef_yy);
			REG_SHIFT_X:  prdata = APB_DATA_W'(shift_x);
			REG_SHIFT_Y:  prdata = APB_DATA_W'(shift_y);
			REG_CENTER_X: prdata = APB_DATA_W'(center_x);
			REG_CENTER_Y: prdata = APB_DATA_W'(center_y);
		endcase
	end

endmodule

[design/abt_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_lane
// Maps one corner through the affine transform: subtract center, multiply,
// floor and sum, then clamp to the coordinate range. Four stages.
// ----------------------------------------------------------------------------
module abt_lane import abt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int COEF_BITS  = COEF_BITS_DEF
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] x,
	input  logic signed [COORD_BITS-1:0] y,
	input  logic signed [COEF_BITS-1:0]  coef_xx,
	input  logic signed [COEF_BITS-1:0]  coef_xy,
	input  logic signed [COEF_BITS-1:0]  coef_yx,
	input  logic signed [COEF_BITS-1:0]  coef_yy,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS:0]   off_x,
	input  logic signed [COORD_BITS:0]   off_y,
	output logic signed [COORD_BITS-1:0] map_x,
	output logic signed [COORD_BITS-1:0] map_y,
	output logic                         sat
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = COEF_BITS + DW;
	localparam int SW = COEF_BITS + COORD_BITS + 4;
	localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

	logic signed [DW-1:0]         dx_s1, dy_s1;
	logic signed [PW-1:0]         pxx_s2, pxy_s2, pyx_s2, pyy_s2;
	logic signed [SW-1:0]         tx_s3, ty_s3;
	logic signed [COORD_BITS-1:0] mx_s4, my_s4;
	logic                         sat_s4;
	logic                         sat_x, sat_y;
	logic signed [COORD_BITS-1:0] cl_x, cl_y;

	always_ff @(posedge clk) begin
		dx_s1 <= {x[COORD_BITS-1], x} - {center_x[COORD_BITS-1], center_x};
		dy_s1 <= {y[COORD_BITS-1], y} - {center_y[COORD_BITS-1], center_y};

		pxx_s2 <= PW'(coef_xx) * PW'(dx_s1);
		pxy_s2 <= PW'(coef_xy) * PW'(dy_s1);
		pyx_s2 <= PW'(coef_yx) * PW'(dx_s1);
		pyy_s2 <= PW'(coef_yy) * PW'(dy_s1);

		// Drop the fraction bits: floor toward minus infinity.
		tx_s3 <= SW'(signed'(pxx_s2[PW-1:COEF_FRAC])) + SW'(signed'(pxy_s2[PW-1:COEF_FRAC]))
		       + SW'(off_x);
		ty_s3 <= SW'(signed'(pyx_s2[PW-1:COEF_FRAC])) + SW'(signed'(pyy_s2[PW-1:COEF_FRAC]))
		       + SW'(off_y);

		mx_s4  <= cl_x;
		my_s4  <= cl_y;
		sat_s4 <= sat_x || sat_y;
	end

	always_comb begin
		sat_x = (tx_s3 > CMAX) || (tx_s3 < CMIN);
		sat_y = (ty_s3 > CMAX) || (ty_s3 < CMIN);
		priority if (tx_s3 > CMAX) cl_x = CMAX[COORD_BITS-1:0];
		else if (tx_s3 < CMIN)     cl_x = CMIN[COORD_BITS-1:0];
		else                       cl_x = tx_s3[COORD_BITS-1:0];
		priority if (ty_s3 > CMAX) cl_y = CMAX[COORD_BITS-1:0];
		else if (ty_s3 < CMIN)     cl_y = CMIN[COORD_BITS-1:0];
		else                       cl_y = ty_s3[COORD_BITS-1:0];
	end

	assign map_x = mx_s4;
	assign map_y = my_s4;
	assign sat   = sat_s4;

endmodule

[design/abt_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_merge
// Combines the four mapped corners into their bounding box and registers
// the result with its strobe.
// ----------------------------------------------------------------------------
module abt_merge import abt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic signed [COORD_BITS-1:0] corner_x [NUM_LANES],
	input  logic signed [COORD_BITS-1:0] corner_y [NUM_LANES],
	input  logic [NUM_LANES-1:0]         corner_sat,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] res_x_lo,
	output logic signed [COORD_BITS-1:0] res_x_hi,
	output logic signed [COORD_BITS-1:0] res_y_lo,
	output logic signed [COORD_BITS-1:0] res_y_hi,
	output logic                         saturated
);

	function automatic logic signed [COORD_BITS-1:0] smin(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] smax(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	// Two-level compare tree per bound.
	always_ff @(posedge clk) begin
		res_x_lo  <= smin(smin(corner_x[0], corner_x[1]), smin(corner_x[2], corner_x[3]));
		res_x_hi  <= smax(smax(corner_x[0], corner_x[1]), smax(corner_x[2], corner_x[3]));
		res_y_lo  <= smin(smin(corner_y[0], corner_y[1]), smin(corner_y[2], corner_y[3]));
		res_y_hi  <= smax(smax(corner_y[0], corner_y[1]), smax(corner_y[2], corner_y[3]));
		saturated <= |corner_sat;
	end

	assign done = done_q;

endmodule

[design/affine_box_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_box_transform
// Maps an axis-aligned box through a 2D affine transform about a center and
// returns the bounding box of the four mapped corners.
// ----------------------------------------------------------------------------
// Usage:
//   Program the matrix, translation and center over the APB port while no
//   request is in flight; reset loads the identity transform, zero shift and
//   zero center. Registers sit at byte addresses 4*i.
//   A request is taken at a clock edge with start high and busy low. busy
//   stays low: four corner lanes, each with four multipliers, take a new
//   request every cycle.
//   The result appears on res_* and saturated with done high for one cycle.
//   Five registers (four lane stages plus the merge register) lie on the
//   path, and the first of them loads on the request edge.
//   The receiver cannot stall; each result is shown exactly once.
//   saturated flags that some mapped coordinate was clamped.
//   Reset clears all in-flight requests.
// ----------------------------------------------------------------------------
module affine_box_transform import abt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int COEF_BITS  = COEF_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] box_x_lo,
	input  logic signed [COORD_BITS-1:0] box_x_hi,
	input  logic signed [COORD_BITS-1:0] box_y_lo,
	input  logic signed [COORD_BITS-1:0] box_y_hi,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] res_x_lo,
	output logic signed [COORD_BITS-1:0] res_x_hi,
	output logic signed [COORD_BITS-1:0] res_y_lo,
	output logic signed [COORD_BITS-1:0] res_y_hi,
	output logic                         saturated
);

	logic signed [COEF_BITS-1:0]  coef_xx, coef_xy, coef_yx, coef_yy;
	logic signed [COORD_BITS-1:0] shift_x, shift_y, center_x, center_y;
	logic signed [COORD_BITS:0]   off_x, off_y;
	logic signed [COORD_BITS-1:0] lane_x [NUM_LANES];
	logic signed [COORD_BITS-1:0] lane_y [NUM_LANES];
	logic signed [COORD_BITS-1:0] corner_x [NUM_LANES];
	logic signed [COORD_BITS-1:0] corner_y [NUM_LANES];
	logic [NUM_LANES-1:0]         corner_sat;
	logic                         vld_s1, vld_s2, vld_s3, vld_s4;

	abt_regs #(
		.COORD_BITS (COORD_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.coef_xx  (coef_xx),
		.coef_xy  (coef_xy),
		.coef_yx  (coef_yx),
		.coef_yy  (coef_yy),
		.shift_x  (shift_x),
		.shift_y  (shift_y),
		.center_x (center_x),
		.center_y (center_y)
	);

	assign busy  = 1'b0;
	assign off_x = {shift_x[COORD_BITS-1], shift_x} + {center_x[COORD_BITS-1], center_x};
	assign off_y = {shift_y[COORD_BITS-1], shift_y} + {center_y[COORD_BITS-1], center_y};

	// Corner order: (xlo,ylo) (xlo,yhi) (xhi,ylo) (xhi,yhi).
	always_comb begin
		lane_x[0] = box_x_lo;  lane_y[0] = box_y_lo;
		lane_x[1] = box_x_lo;  lane_y[1] = box_y_hi;
		lane_x[2] = box_x_hi;  lane_y[2] = box_y_lo;
		lane_x[3] = box_x_hi;  lane_y[3] = box_y_hi;
	end

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		abt_lane #(
			.COORD_BITS (COORD_BITS),
			.COEF_BITS  (COEF_BITS)
		) u_lane (
			.clk      (clk),
			.x        (lane_x[k]),
			.y        (lane_y[k]),
			.coef_xx  (coef_xx),
			.coef_xy  (coef_xy),
			.coef_yx  (coef_yx),
			.coef_yy  (coef_yy),
			.center_x (center_x),
			.center_y (center_y),
			.off_x    (off_x),
			.off_y    (off_y),
			.map_x    (corner_x[k]),
			.map_y    (corner_y[k]),
			.sat      (corner_sat[k])
		);
	end

	// Advance the request marker alongside the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	abt_merge #(
		.COORD_BITS (COORD_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (vld_s4),
		.corner_x   (corner_x),
		.corner_y   (corner_y),
		.corner_sat (corner_sat),
		.done       (done),
		.res_x_lo   (res_x_lo),
		.res_x_hi   (res_x_hi),
		.res_y_lo   (res_y_lo),
		.res_y_hi   (res_y_hi),
		.saturated  (saturated)
	);

endmodule

[design/abt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_checker
// Port-level checks of request latency and result ordering.
// ----------------------------------------------------------------------------
`include "affine_box_transform_defines.svh"

module abt_checker import abt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic signed [COORD_BITS-1:0] res_x_lo,
	input logic signed [COORD_BITS-1:0] res_x_hi,
	input logic signed [COORD_BITS-1:0] res_y_lo,
	input logic signed [COORD_BITS-1:0] res_y_hi
);

	// Every taken request produces a result a fixed time later.
	`ABT_ASSERT_AFTER(a_req_gives_done, clk, arst_n, start && !busy, 5, done, "request without result")

	// No result without a request behind it.
	`ABT_ASSERT_NOW(a_done_has_req, clk, arst_n, done, $past(start && !busy, 5), "spurious result")

	// The bounding box is always ordered, also for reversed input boxes.
	`ABT_ASSERT_NOW(a_box_ordered, clk, arst_n, done, (res_x_lo <= res_x_hi) && (res_y_lo <= res_y_hi), "unordered result box")

endmodule

bind affine_box_transform abt_checker #(.COORD_BITS(COORD_BITS)) u_abt_checker (.*);
